/* design/ded_pkg.sv */
// shared types and constants of the digitizer event deframer
// no dependencies

package ded_pkg;

    localparam int NUM_CHANNELS     = 8;
    localparam int MAX_PACKET_WORDS = 1048576;

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LEN_W    = 21;
    localparam int BYTES_W  = 23;
    localparam int EXT_W    = 63;

    localparam logic [31:0]      MAX_WORDS_32 = 32'(MAX_PACKET_WORDS);
    localparam logic [LEN_W-1:0] MAX_LEN      = LEN_W'(MAX_PACKET_WORDS);

    localparam logic [7:0] CH_MASK =
        (NUM_CHANNELS >= 8) ? 8'hFF : 8'((1 << NUM_CHANNELS) - 1);

    localparam logic [11:0] EVENT_TAG      = 12'hA00;
    localparam logic [31:0] PAD_WORD       = 32'hFFFF_FFFF;
    localparam logic [31:0] TIME_UNSEEN    = 32'hFFFF_FFFF;
    localparam logic [31:0] TIME_HIGH      = 32'd1500000000;
    localparam logic [31:0] TIME_LOW       = 32'd500000000;
    localparam logic [1:0]  HDR_MASK_STEP  = 2'd1;
    localparam logic [1:0]  HDR_LAST_STEP  = 2'd3;
    localparam logic [31:0] MIN_SIZE       = 32'd2;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

endpackage

/* design/digitizer_event_deframer.sv */
// digitizer event deframer top level: packet scan, channel records, time extension
// depends on ded_pkg

// Takes one readout word per cycle and gives at most one result word per cycle
// from a single result register, so a sustained rate of one word per clock while
// the output is not stalled; each word goes through one pass of state update, a
// 32-bit rollover compare and increment, and the record size check. The input is
// stalled only while a finished result waits in the result register and the
// output is stalled. Per-channel time tracking (last time seen, rollover count)
// sits in flip-flops and is reloaded on every accepted word flagged packet_first.
module digitizer_event_deframer (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [31:0]                   word,
    input  logic                          packet_first,
    input  logic [15:0]                   module_id,
    input  logic [31:0]                   packet_clock_counter,
    input  logic [31:0]                   hdr_stamp,
    input  logic [ded_pkg::LEN_W-1:0]     packet_words,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [1:0]                    kind,
    output logic [15:0]                   module_out,
    output logic [2:0]                    channel,
    output logic [30:0]                   chan_stamp,
    output logic [ded_pkg::BYTES_W-1:0]   payload_bytes,
    output logic [ded_pkg::EXT_W-1:0]     time_extended,
    output logic [31:0]                   payload_word,
    output logic                          last_of_record
);

    typedef enum logic [2:0] {
        PH_STOPPED,
        PH_SCAN,
        PH_HEADER,
        PH_SIZE,
        PH_TIME,
        PH_TIME_BAD,
        PH_PAYLOAD
    } phase_t;

    phase_t                         phase_reg, phase_next, phase_eff;
    logic [ded_pkg::LEN_W-1:0]      word_index_reg, word_index_next, idx_eff;
    logic [ded_pkg::LEN_W-1:0]      packet_length_reg, packet_length_next, len_eff, len_clamp;
    logic [1:0]                     header_step_reg, header_step_next;
    logic [7:0]                     pending_mask_reg, pending_mask_next;
    logic [2:0]                     current_channel_reg, current_channel_next;
    logic [ded_pkg::LEN_W-1:0]      payload_left_reg, payload_left_next;
    logic [15:0]                    packet_module_reg, packet_module_next;
    logic [31:0]                    packet_hdr_stamp_reg, packet_hdr_stamp_next;
    logic [30:0]                    rec_time_reg, rec_time_next;
    logic [ded_pkg::BYTES_W-1:0]    rec_bytes_reg, rec_bytes_next;
    logic [ded_pkg::EXT_W-1:0]      rec_ext_reg, rec_ext_next;

    logic [31:0] last_time_seen_reg [ded_pkg::NUM_CHANNELS];
    logic [31:0] rollover_count_reg [ded_pkg::NUM_CHANNELS];

    logic                           result_valid_reg, result_valid_next;
    ded_pkg::kind_t                 kind_reg, kind_next;
    logic [15:0]                    module_out_reg;
    logic [2:0]                     channel_reg;
    logic [30:0]                    chan_stamp_reg;
    logic [ded_pkg::BYTES_W-1:0]    payload_bytes_reg, bytes_next;
    logic [ded_pkg::EXT_W-1:0]      time_extended_reg;
    logic [31:0]                    payload_word_reg, pw_next;
    logic                           last_of_record_reg, last_next;

    logic                           item_acc;
    logic                           produce;
    logic                           time_wr;
    logic [ded_pkg::CH_IDX_W-1:0]   ch_idx;
    logic [30:0]                    ct;
    logic [31:0]                    last_seen;
    logic [31:0]                    roll_cur;
    logic [31:0]                    roll_new;
    logic [ded_pkg::EXT_W-1:0]      ext_new;
    logic [32:0]                    rec_end;
    logic [ded_pkg::LEN_W-1:0]      size_left;
    logic [ded_pkg::LEN_W-1:0]      pl_dec;
    logic [7:0]                     mask_after;

    function automatic logic [2:0] lowest_set(input logic [7:0] m);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    assign item_stall = result_valid_reg && result_stall;
    assign item_acc   = item_valid && !item_stall;

    // per-channel time extension
    always_comb
    begin
        ch_idx    = ded_pkg::CH_IDX_W'(current_channel_reg);
        ct        = word[30:0];
        last_seen = last_time_seen_reg[ch_idx];
        roll_cur  = rollover_count_reg[ch_idx];
        roll_new  = roll_cur;
        if (last_seen == ded_pkg::TIME_UNSEEN)
        begin
            if ({1'b0, ct} > ded_pkg::TIME_HIGH && packet_hdr_stamp_reg < ded_pkg::TIME_LOW)
            begin
                roll_new = roll_cur - 32'd1;
            end
            else if ({1'b0, ct} < ded_pkg::TIME_LOW
                     && packet_hdr_stamp_reg > ded_pkg::TIME_HIGH)
            begin
                roll_new = roll_cur + 32'd1;
            end
        end
        else if ({1'b0, ct} < last_seen)
        begin
            roll_new = roll_cur + 32'd1;
        end
        ext_new = {roll_new, ct};
    end

    always_comb
    begin
        if (32'(packet_words) > ded_pkg::MAX_WORDS_32)
        begin
            len_clamp = ded_pkg::MAX_LEN;
        end
        else
        begin
            len_clamp = packet_words;
        end

        phase_eff = packet_first ? PH_SCAN : phase_reg;
        idx_eff   = packet_first ? '0 : word_index_reg;
        len_eff   = packet_first ? len_clamp : packet_length_reg;

        phase_next              = phase_eff;
        word_index_next         = idx_eff;
        packet_length_next      = len_eff;
        header_step_next        = packet_first ? 2'd0 : header_step_reg;
        pending_mask_next       = packet_first ? 8'd0 : pending_mask_reg;
        current_channel_next    = packet_first ? 3'd0 : current_channel_reg;
        payload_left_next       = packet_first ? '0 : payload_left_reg;
        packet_module_next      = packet_first ? module_id : packet_module_reg;
        packet_hdr_stamp_next   = packet_first ? hdr_stamp : packet_hdr_stamp_reg;
        rec_time_next           = rec_time_reg;
        rec_bytes_next          = rec_bytes_reg;
        rec_ext_next            = rec_ext_reg;

        produce   = 1'b0;
        time_wr   = 1'b0;
        kind_next = ded_pkg::KIND_HEADER;
        bytes_next = rec_bytes_reg;
        pw_next   = 32'd0;
        last_next = 1'b0;

        rec_end    = 33'(idx_eff) + 33'(word);
        size_left  = ded_pkg::LEN_W'(word - ded_pkg::MIN_SIZE);
        pl_dec     = payload_left_reg - ded_pkg::LEN_W'(1);
        mask_after = pending_mask_reg & ~(8'd1 << current_channel_reg);

        if (!item_acc)
        begin
            phase_next              = phase_reg;
            word_index_next         = word_index_reg;
            packet_length_next      = packet_length_reg;
            header_step_next        = header_step_reg;
            pending_mask_next       = pending_mask_reg;
            current_channel_next    = current_channel_reg;
            payload_left_next       = payload_left_reg;
            packet_module_next      = packet_module_reg;
            packet_hdr_stamp_next   = packet_hdr_stamp_reg;
        end
        else if (phase_eff != PH_STOPPED)
        begin
            if (idx_eff >= len_eff)
            begin
                phase_next = PH_STOPPED;
            end
            else
            begin
                word_index_next = idx_eff + ded_pkg::LEN_W'(1);
                unique case (phase_eff)
                    PH_SCAN:
                    begin
                        if (word == ded_pkg::PAD_WORD)
                        begin
                            phase_next = PH_STOPPED;
                        end
                        else if (word[31:20] == ded_pkg::EVENT_TAG)
                        begin
                            header_step_next = 2'd1;
                            phase_next       = PH_HEADER;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (header_step_reg == ded_pkg::HDR_MASK_STEP)
                        begin
                            pending_mask_next = word[7:0] & ded_pkg::CH_MASK;
                        end
                        if (header_step_reg == ded_pkg::HDR_LAST_STEP)
                        begin
                            header_step_next = 2'd0;
                            if (pending_mask_reg == 8'd0)
                            begin
                                phase_next = PH_SCAN;
                            end
                            else
                            begin
                                current_channel_next = lowest_set(pending_mask_reg);
                                phase_next           = PH_SIZE;
                            end
                        end
                        else
                        begin
                            header_step_next = header_step_reg + 2'd1;
                        end
                    end
                    PH_SIZE:
                    begin
                        if (word >= ded_pkg::MIN_SIZE && rec_end <= 33'(len_eff))
                        begin
                            payload_left_next = size_left;
                            rec_bytes_next    = {size_left, 2'b00};
                            phase_next        = PH_TIME;
                        end
                        else
                        begin
                            payload_left_next = '0;
                            rec_bytes_next    = '0;
                            phase_next        = PH_TIME_BAD;
                        end
                    end
                    PH_TIME_BAD:
                    begin
                        time_wr       = 1'b1;
                        rec_time_next = ct;
                        rec_ext_next  = ext_new;
                        produce       = 1'b1;
                        kind_next     = ded_pkg::KIND_ERROR;
                        bytes_next    = '0;
                        phase_next    = PH_STOPPED;
                    end
                    PH_TIME:
                    begin
                        time_wr       = 1'b1;
                        rec_time_next = ct;
                        rec_ext_next  = ext_new;
                        produce       = 1'b1;
                        kind_next     = ded_pkg::KIND_HEADER;
                        if (payload_left_reg == '0)
                        begin
                            last_next         = 1'b1;
                            pending_mask_next = mask_after;
                            if (mask_after == 8'd0)
                            begin
                                phase_next = PH_SCAN;
                            end
                            else
                            begin
                                current_channel_next = lowest_set(mask_after);
                                phase_next           = PH_SIZE;
                            end
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        payload_left_next = pl_dec;
                        produce           = 1'b1;
                        kind_next         = ded_pkg::KIND_PAYLOAD;
                        pw_next           = word;
                        if (pl_dec == '0)
                        begin
                            last_next         = 1'b1;
                            pending_mask_next = mask_after;
                            if (mask_after == 8'd0)
                            begin
                                phase_next = PH_SCAN;
                            end
                            else
                            begin
                                current_channel_next = lowest_set(mask_after);
                                phase_next           = PH_SIZE;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_STOPPED;
                    end
                endcase
            end
        end

        if (produce)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg              <= PH_STOPPED;
            word_index_reg         <= '0;
            packet_length_reg      <= '0;
            header_step_reg        <= 2'd0;
            pending_mask_reg       <= 8'd0;
            current_channel_reg    <= 3'd0;
            payload_left_reg       <= '0;
            packet_module_reg      <= 16'd0;
            packet_hdr_stamp_reg   <= 32'd0;
            rec_time_reg           <= '0;
            rec_bytes_reg          <= '0;
            rec_ext_reg            <= '0;
            result_valid_reg       <= 1'b0;
            kind_reg               <= ded_pkg::KIND_HEADER;
            module_out_reg         <= 16'd0;
            channel_reg            <= 3'd0;
            chan_stamp_reg         <= '0;
            payload_bytes_reg      <= '0;
            time_extended_reg      <= '0;
            payload_word_reg       <= 32'd0;
            last_of_record_reg     <= 1'b0;
            for (int i = 0; i < ded_pkg::NUM_CHANNELS; i++)
            begin
                last_time_seen_reg[i] <= ded_pkg::TIME_UNSEEN;
                rollover_count_reg[i] <= 32'd0;
            end
        end
        else
        begin
            phase_reg              <= phase_next;
            word_index_reg         <= word_index_next;
            packet_length_reg      <= packet_length_next;
            header_step_reg        <= header_step_next;
            pending_mask_reg       <= pending_mask_next;
            current_channel_reg    <= current_channel_next;
            payload_left_reg       <= payload_left_next;
            packet_module_reg      <= packet_module_next;
            packet_hdr_stamp_reg   <= packet_hdr_stamp_next;
            rec_time_reg           <= rec_time_next;
            rec_bytes_reg          <= rec_bytes_next;
            rec_ext_reg            <= rec_ext_next;
            result_valid_reg       <= result_valid_next;
            // result word register
            if (produce)
            begin
                kind_reg           <= kind_next;
                module_out_reg     <= packet_module_reg;
                channel_reg        <= current_channel_reg;
                chan_stamp_reg     <= rec_time_next;
                payload_bytes_reg  <= bytes_next;
                time_extended_reg  <= rec_ext_next;
                payload_word_reg   <= pw_next;
                last_of_record_reg <= last_next;
            end
            if (item_acc && packet_first)
            begin
                for (int i = 0; i < ded_pkg::NUM_CHANNELS; i++)
                begin
                    last_time_seen_reg[i] <= ded_pkg::TIME_UNSEEN;
                    rollover_count_reg[i] <= packet_clock_counter;
                end
            end
            else if (time_wr)
            begin
                last_time_seen_reg[ch_idx] <= {1'b0, ct};
                rollover_count_reg[ch_idx] <= roll_new;
            end
        end
    end

    assign result_valid   = result_valid_reg;
    assign kind           = kind_reg;
    assign module_out     = module_out_reg;
    assign channel        = channel_reg;
    assign chan_stamp     = chan_stamp_reg;
    assign payload_bytes  = payload_bytes_reg;
    assign time_extended  = time_extended_reg;
    assign payload_word   = payload_word_reg;
    assign last_of_record = last_of_record_reg;

    a_index_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        word_index_reg <= packet_length_reg)
        else $error("word index past packet length");

    a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_mask_reg & ~ded_pkg::CH_MASK) == 8'd0)
        else $error("pending mask holds a channel that does not exist");

    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> payload_left_reg != '0)
        else $error("payload phase with no words left");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        produce && kind_next == ded_pkg::KIND_ERROR |=> phase_reg == PH_STOPPED)
        else $error("packet not stopped after record error");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        produce |-> (phase_reg == PH_TIME || phase_reg == PH_TIME_BAD
                     || phase_reg == PH_PAYLOAD))
        else $error("result word outside a channel record");

endmodule

/* test/digitizer_event_deframer_test.sv */
// self-checking testbench of the digitizer event deframer: directed and random readout packets
// predicts channel records and payload words in step with the input handshake
// depends on ded_pkg and digitizer_event_deframer
`timescale 1ns / 1ps

module digitizer_event_deframer_test;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        ST_STOPPED,
        ST_SCAN,
        ST_HEADER,
        ST_SIZE,
        ST_TIME,
        ST_TIME_BAD,
        ST_PAYLOAD
    } frame_state_t;

    typedef struct {
        ded_pkg::kind_t             kind;
        logic [15:0]                board;
        logic [2:0]                 channel;
        logic [30:0]                chan_stamp;
        logic [ded_pkg::BYTES_W-1:0] payload_bytes;
        logic [ded_pkg::EXT_W-1:0]  time_extended;
        logic [31:0]                payload_word;
        logic                       last_flag;
    } record_word_t;

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_stall;
    logic [31:0]                 word;
    logic                        packet_first;
    logic [15:0]                 module_id;
    logic [31:0]                 packet_clock_counter;
    logic [31:0]                 hdr_stamp;
    logic [ded_pkg::LEN_W-1:0]   packet_words;
    logic                        result_valid;
    logic                        result_stall;
    logic [1:0]                  kind;
    logic [15:0]                 module_out;
    logic [2:0]                  channel;
    logic [30:0]                 chan_stamp;
    logic [ded_pkg::BYTES_W-1:0] payload_bytes;
    logic [ded_pkg::EXT_W-1:0]   time_extended;
    logic [31:0]                 payload_word;
    logic                        last_of_record;

    record_word_t  expected_records[$];
    logic [31:0]   pkt_words[$];
    int            mismatches = 0;
    int            words_sent = 0;
    int            cycle_count = 0;
    int            sender_idle_pct = 0;
    int            stall_pct = 0;
    int            hold_cycles = 0;

    frame_state_t                frame_state;
    logic [ded_pkg::LEN_W-1:0]   word_pos;
    logic [1:0]                  hdr_step;
    logic [7:0]                  pending;
    logic [2:0]                  cur_channel;
    logic [ded_pkg::LEN_W-1:0]   payload_left;
    logic [31:0]                 last_seen[ded_pkg::NUM_CHANNELS];
    logic [31:0]                 rollover[ded_pkg::NUM_CHANNELS];
    logic [15:0]                 pkt_board;
    logic [31:0]                 pkt_htime;
    logic [ded_pkg::LEN_W-1:0]   pkt_length;
    logic [30:0]                 rec_time;
    logic [ded_pkg::BYTES_W-1:0] rec_bytes;
    logic [ded_pkg::EXT_W-1:0]   rec_ext;

    digitizer_event_deframer u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_valid           (item_valid),
        .item_stall           (item_stall),
        .word                 (word),
        .packet_first         (packet_first),
        .module_id            (module_id),
        .packet_clock_counter (packet_clock_counter),
        .hdr_stamp            (hdr_stamp),
        .packet_words         (packet_words),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .kind                 (kind),
        .module_out           (module_out),
        .channel              (channel),
        .chan_stamp           (chan_stamp),
        .payload_bytes        (payload_bytes),
        .time_extended        (time_extended),
        .payload_word         (payload_word),
        .last_of_record       (last_of_record)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("digitizer_event_deframer_test NOT OK");
            $finish;
        end
    end

    // receiver side: random stalls, or a long hold when asked for
    initial
    begin
        int held;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                held = hold_cycles;
                hold_cycles = 0;
                repeat (held)
                begin
                    result_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        record_word_t exp_rec;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_records.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none actual kind %0d",
                         $time, kind);
            end
            else
            begin
                exp_rec = expected_records.pop_front();
                check_field("kind", exp_rec.kind, kind);
                check_field("module_out", exp_rec.board, module_out);
                check_field("channel", exp_rec.channel, channel);
                check_field("chan_stamp", exp_rec.chan_stamp, chan_stamp);
                check_field("payload_bytes", exp_rec.payload_bytes, payload_bytes);
                check_field("time_extended", exp_rec.time_extended, time_extended);
                check_field("payload_word", exp_rec.payload_word, payload_word);
                check_field("last_of_record", exp_rec.last_flag, last_of_record);
            end
        end
    end

    function automatic void add_word(logic [31:0] w);
        pkt_words.insert(pkt_words.size(), w);
    endfunction

    function automatic void deframe_reset();
        frame_state  = ST_STOPPED;
        word_pos     = '0;
        hdr_step     = '0;
        pending      = '0;
        cur_channel  = '0;
        payload_left = '0;
        pkt_board    = '0;
        pkt_htime    = '0;
        pkt_length   = '0;
        rec_time     = '0;
        rec_bytes    = '0;
        rec_ext      = '0;
        for (int c = 0; c < ded_pkg::NUM_CHANNELS; c++)
        begin
            last_seen[c] = ded_pkg::TIME_UNSEEN;
            rollover[c]  = '0;
        end
    endfunction

    function automatic void queue_record(ded_pkg::kind_t k,
                                         logic [ded_pkg::BYTES_W-1:0] bytes,
                                         logic [31:0] pw, logic last_flag);
        record_word_t r;
        r.kind          = k;
        r.board         = pkt_board;
        r.channel       = cur_channel;
        r.chan_stamp    = rec_time;
        r.payload_bytes = bytes;
        r.time_extended = rec_ext;
        r.payload_word  = pw;
        r.last_flag     = last_flag;
        expected_records.insert(expected_records.size(), r);
    endfunction

    function automatic void next_channel();
        if (pending == 8'h00)
        begin
            frame_state = ST_SCAN;
            return;
        end
        for (int c = 7; c >= 0; c--)
            if (pending[c])
                cur_channel = 3'(c);
        frame_state = ST_SIZE;
    endfunction

    function automatic void close_channel();
        pending[cur_channel] = 1'b0;
        next_channel();
    endfunction

    function automatic void stamp_time(logic [31:0] w);
        int          ch;
        logic [31:0] ct;
        ch = cur_channel % ded_pkg::NUM_CHANNELS;
        ct = {1'b0, w[30:0]};
        if (last_seen[ch] == ded_pkg::TIME_UNSEEN)
        begin
            if (ct > ded_pkg::TIME_HIGH && pkt_htime < ded_pkg::TIME_LOW)
                rollover[ch] = rollover[ch] - 1;
            else if (ct < ded_pkg::TIME_LOW && pkt_htime > ded_pkg::TIME_HIGH)
                rollover[ch] = rollover[ch] + 1;
        end
        else if (ct < last_seen[ch])
            rollover[ch] = rollover[ch] + 1;
        last_seen[ch] = ct;
        rec_time = ct[30:0];
        rec_ext  = {rollover[ch], ct[30:0]};
    endfunction

    function automatic void deframe_predict(logic [31:0] w, logic first, logic [15:0] board,
                                            logic [31:0] pcc, logic [31:0] ht,
                                            logic [ded_pkg::LEN_W-1:0] len);
        logic [ded_pkg::LEN_W-1:0] pos;
        if (first)
        begin
            pkt_length = (len > ded_pkg::MAX_LEN) ? ded_pkg::MAX_LEN : len;
            pkt_board  = board;
            pkt_htime  = ht;
            for (int c = 0; c < ded_pkg::NUM_CHANNELS; c++)
            begin
                last_seen[c] = ded_pkg::TIME_UNSEEN;
                rollover[c]  = pcc;
            end
            word_pos     = '0;
            hdr_step     = '0;
            pending      = '0;
            cur_channel  = '0;
            payload_left = '0;
            frame_state  = ST_SCAN;
        end
        if (frame_state == ST_STOPPED)
            return;
        if (word_pos >= pkt_length)
        begin
            frame_state = ST_STOPPED;
            return;
        end
        pos = word_pos;
        word_pos = word_pos + 1;
        case (frame_state)
            ST_SCAN:
            begin
                if (w == ded_pkg::PAD_WORD)
                    frame_state = ST_STOPPED;
                else if (w[31:20] == ded_pkg::EVENT_TAG)
                begin
                    hdr_step    = ded_pkg::HDR_MASK_STEP;
                    frame_state = ST_HEADER;
                end
            end
            ST_HEADER:
            begin
                if (hdr_step == ded_pkg::HDR_MASK_STEP)
                    pending = w[7:0] & ded_pkg::CH_MASK;
                if (hdr_step >= ded_pkg::HDR_LAST_STEP)
                begin
                    hdr_step = '0;
                    next_channel();
                end
                else
                    hdr_step = hdr_step + 1;
            end
            ST_SIZE:
            begin
                if (w >= ded_pkg::MIN_SIZE && (64'(pos) + 64'(w)) <= 64'(pkt_length))
                begin
                    payload_left = ded_pkg::LEN_W'(w - ded_pkg::MIN_SIZE);
                    rec_bytes    = ded_pkg::BYTES_W'(payload_left * 4);
                    frame_state  = ST_TIME;
                end
                else
                begin
                    payload_left = '0;
                    rec_bytes    = '0;
                    frame_state  = ST_TIME_BAD;
                end
            end
            ST_TIME_BAD:
            begin
                stamp_time(w);
                queue_record(ded_pkg::KIND_ERROR, '0, '0, 1'b0);
                frame_state = ST_STOPPED;
            end
            ST_TIME:
            begin
                stamp_time(w);
                if (payload_left == 0)
                begin
                    queue_record(ded_pkg::KIND_HEADER, rec_bytes, '0, 1'b1);
                    close_channel();
                end
                else
                begin
                    queue_record(ded_pkg::KIND_HEADER, rec_bytes, '0, 1'b0);
                    frame_state = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                payload_left = payload_left - 1;
                queue_record(ded_pkg::KIND_PAYLOAD, rec_bytes, w, payload_left == 0);
                if (payload_left == 0)
                    close_channel();
            end
            default:
                frame_state = ST_STOPPED;
        endcase
    endfunction

    task automatic send_word(logic [31:0] w, logic first, logic [15:0] board,
                             logic [31:0] pcc, logic [31:0] ht,
                             logic [ded_pkg::LEN_W-1:0] len);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid           <= 1'b1;
        word                 <= w;
        packet_first         <= first;
        module_id            <= board;
        packet_clock_counter <= pcc;
        hdr_stamp            <= ht;
        packet_words         <= len;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        deframe_predict(w, first, board, pcc, ht, len);
        words_sent++;
    endtask

    task automatic send_packet(logic [15:0] board, logic [31:0] pcc, logic [31:0] ht,
                               logic [ded_pkg::LEN_W-1:0] len);
        foreach (pkt_words[i])
        begin
            if (i == 0)
                send_word(pkt_words[i], 1'b1, board, pcc, ht, len);
            else
                send_word(pkt_words[i], 1'b0, 16'($urandom()), $urandom(), $urandom(),
                          ded_pkg::LEN_W'($urandom()));
        end
    endtask

    function automatic logic [31:0] junk_word();
        logic [31:0] w;
        w = $urandom();
        if (w[31:20] == ded_pkg::EVENT_TAG || w == ded_pkg::PAD_WORD)
            w[31] = 1'b0;
        return w;
    endfunction

    // times clustered around the rollover thresholds and the ends of the range
    function automatic logic [31:0] pick_time();
        logic [30:0] t;
        case ($urandom_range(5))
            0: t = 31'($urandom());
            1: t = 31'(ded_pkg::TIME_HIGH + $urandom_range(2) - 1);
            2: t = 31'(ded_pkg::TIME_LOW + $urandom_range(2) - 1);
            3: t = 31'($urandom_range(1000));
            4: t = 31'h7FFF_FFFF - 31'($urandom_range(1000));
            default: t = 31'($urandom_range(2000000000));
        endcase
        return {1'($urandom_range(1)), t};
    endfunction

    function automatic void add_event(logic corrupt);
        logic [7:0] mask;
        int         n;
        logic       broken;
        broken = corrupt;
        case ($urandom_range(4))
            0: mask = 8'h00;
            1: mask = 8'h01 << $urandom_range(7);
            2: mask = 8'hFF;
            default: mask = 8'($urandom());
        endcase
        if (corrupt && mask == 8'h00)
            mask = 8'h01 << $urandom_range(7);
        add_word({ded_pkg::EVENT_TAG, 20'($urandom())});
        add_word({24'($urandom()), mask});
        add_word($urandom());
        add_word($urandom());
        for (int c = 0; c < 8; c++)
        begin
            if (mask[c])
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(4);
                if (broken)
                begin
                    case ($urandom_range(2))
                        0: add_word(32'd0);
                        1: add_word(32'd1);
                        default: add_word($urandom());
                    endcase
                    broken = 1'b0;
                end
                else
                    add_word(32'(n + 2));
                add_word(pick_time());
                repeat (n) add_word($urandom());
            end
        end
    endfunction

    task automatic send_random_packet();
        int                        events;
        logic                      corrupt;
        logic [ded_pkg::LEN_W-1:0] len;
        logic [31:0]               pcc;
        pkt_words.delete();
        repeat ($urandom_range(2)) add_word(junk_word());
        corrupt = ($urandom_range(4) == 0);
        events = $urandom_range(1, 2);
        for (int e = 0; e < events; e++)
            add_event(corrupt && e == events - 1);
        case ($urandom_range(3))
            0:
            begin
                add_word(ded_pkg::PAD_WORD);
                len = ded_pkg::LEN_W'(pkt_words.size() + $urandom_range(3));
                repeat ($urandom_range(2)) add_word($urandom());
            end
            1:
            begin
                len = ded_pkg::LEN_W'(pkt_words.size());
                repeat ($urandom_range(1)) add_word($urandom());
            end
            2:
                len = ded_pkg::LEN_W'(pkt_words.size() + $urandom_range(1, 20));
            default:
            begin
                if ($urandom_range(1))
                    len = ded_pkg::LEN_W'($urandom_range(pkt_words.size()));
                else
                    len = ded_pkg::LEN_W'($urandom());
            end
        endcase
        case ($urandom_range(2))
            0: pcc = 32'hFFFF_FFFF;
            1: pcc = 32'h0;
            default: pcc = $urandom();
        endcase
        send_packet(16'($urandom()), pcc, pick_time(), len);
    endtask

    task automatic run_random_words(int budget);
        int stop_at;
        stop_at = words_sent + budget;
        while (words_sent < stop_at)
            send_random_packet();
    endtask

    task automatic test_directed_packets();
        sender_idle_pct = 0;
        stall_pct = 0;
        // junk, header with channels 0 and 7, empty record, one payload word, padding
        pkt_words = '{32'h1234_5678, {ded_pkg::EVENT_TAG, 20'hFFFFF}, 32'hFFFF_FF81, 32'h0,
                      32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF, 32'd3, 32'h0, 32'hFFFF_FFFF,
                      ded_pkg::PAD_WORD, 32'h0};
        send_packet(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 21'd11);
        // size below minimum, packet length clamped
        pkt_words = '{{ded_pkg::EVENT_TAG, 20'h0}, 32'h0000_0001, 32'h0, 32'h0, 32'd1,
                      32'h7FFF_FFFF, 32'h0};
        send_packet(16'h0000, 32'h0, 32'h0, 21'h1F_FFFF);
        // zero length packet
        pkt_words = '{{ded_pkg::EVENT_TAG, 20'h0}};
        send_packet(16'h5A5A, $urandom(), $urandom(), 21'd0);
        // record running past the packet end
        pkt_words = '{{ded_pkg::EVENT_TAG, 20'h1}, 32'h0000_0002, 32'h0, 32'h0, 32'd5,
                      32'd100};
        send_packet(16'h00A5, 32'h1, 32'd1000, 21'd7);
        // packet ending inside the event header
        pkt_words = '{{ded_pkg::EVENT_TAG, 20'h2}, 32'h0000_0001, 32'h0, 32'h0};
        send_packet(16'h1234, 32'h2, 32'd2000000000, 21'd3);
    endtask

    task automatic test_streaming();
        sender_idle_pct = 0;
        stall_pct = 0;
        run_random_words(250);
    endtask

    task automatic test_sender_gaps();
        sender_idle_pct = 69;
        stall_pct = 0;
        run_random_words(220);
    endtask

    task automatic test_receiver_stalls();
        sender_idle_pct = 0;
        stall_pct = 69;
        run_random_words(220);
    endtask

    task automatic test_both_idle();
        sender_idle_pct = 10;
        stall_pct = 10;
        run_random_words(220);
    endtask

    task automatic test_full_backpressure();
        sender_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 300;
        run_random_words(150);
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        item_valid           <= 1'b0;
        word                 <= '0;
        packet_first         <= 1'b0;
        module_id            <= '0;
        packet_clock_counter <= '0;
        hdr_stamp            <= '0;
        packet_words         <= '0;
        deframe_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_packets();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_full_backpressure();

        item_valid <= 1'b0;
        stall_pct = 0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("digitizer_event_deframer_test OK");
        else
            $display("digitizer_event_deframer_test NOT OK");
        $finish;
    end

endmodule
